FILE: rtl/core/mf3_pkg.sv
// Shared constants, codes and types of the 3x3 median filter.
// Used by the channel interfaces, the filter top level and its checker.
`timescale 1ns / 1ps

package mf3_pkg;

	// Storage and field sizes
	localparam int MAX_WIDTH      = 1024;
	localparam int PIXEL_BITS     = 8;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS     = 11;
	localparam int HEIGHT_BITS    = 12;
	// The input row runs up to two rows past the last row while the frame drains.
	localparam int ROW_BITS       = HEIGHT_BITS + 1;
	localparam int CFG_BITS       = 12;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

	typedef logic [PIXEL_BITS-1:0]  pix_t;
	typedef logic [COL_BITS-1:0]    col_t;
	typedef logic [ROW_BITS-1:0]    row_t;
	typedef logic [HEIGHT_BITS-1:0] orow_t;

	// Kind of an input transaction
	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_index_t;

endpackage

FILE: rtl/core/mf3_if.sv
// Valid/ready channel interfaces of the 3x3 median filter.
// Depends on mf3_pkg for the pixel type.
`timescale 1ns / 1ps

// Input channel: pixel or drain requests
interface mf3_in_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	logic req_type;
	pix_t pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// Output channel: filtered pixels in raster order
interface mf3_out_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic last_of_frame;

	modport source (output valid, output pixel_out, output last_of_frame, input ready);
	modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

FILE: rtl/core/median_filter_3x3.sv
// Top level of the 3x3 median filter: position control, line store, window and
// median network. Depends on mf3_pkg, mf3_in_if, mf3_out_if and mf3_ram.
`timescale 1ns / 1ps

// Usage
// Pixels of a frame enter on "pixels" in raster order as pixel transactions
// (req_type 0). Once all pixels are in, the sender issues drain transactions
// (req_type 1); each releases one pending output. Filtered pixels leave on
// "filtered" in raster order, the final one of the frame with last_of_frame set.
// Interior pixels get the median of their 3x3 neighborhood; border pixels pass.
// A pixel transaction sent after the frame is complete, or a drain sent
// before, is taken and dropped.
// Outputs trail the transaction that completes their neighborhood, which comes
// one row plus one pixel after the pixel. Throughput: one transaction per cycle
// while the output queue has room, set by the single read-modify-write of the
// line store per pixel; a one-row frame's first drain waits on a virtual pixel.
// Frame width and height are written on the cfg port while the block is idle;
// a write restarts the frame. Reset selects 640x480 and empties the pipeline.
// The line store is not cleared: every pixel that reaches an interior median
// was written during the current frame.
// When the receiver stalls, results collect in a two-entry output queue; once
// it is full the whole pipeline holds and pixels.ready drops.
module median_filter_3x3 import mf3_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data,
	mf3_in_if.sink                    pixels,
	mf3_out_if.source                 filtered
);

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_pair_t;

	typedef struct packed {
		pix_t lo;
		pix_t mid;
		pix_t hi;
	} sort3_t;

	typedef struct packed {
		pix_t pixel;
		logic last;
	} out_item_t;

	// Three-input sorter built from three compare-exchange steps.
	function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
		pix_t   x;
		pix_t   y;
		pix_t   z;
		pix_t   t;
		sort3_t r;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		r.lo  = x;
		r.mid = y;
		r.hi  = z;
		return r;
	endfunction

	// Configuration registers
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;

	// Position counters
	col_t  in_col_q;
	row_t  in_row_q;
	col_t  out_col_q;
	orow_t out_row_q;

	// Effective frame size
	logic [COL_BITS:0]      w_eff;
	col_t                   w_last;
	logic [HEIGHT_BITS-1:0] h_eff;
	orow_t                  h_last;

	// Issue stage
	logic frame_in_done;
	logic emit0;
	logic is_drain;
	logic pre_step;
	logic accept;
	logic take;
	logic issue;
	logic adv;
	pix_t pix0;
	logic interior0;
	logic last0;

	// Line store stage
	logic       v_s1;
	col_t       addr_s1;
	pix_t       pix_s1;
	logic       emit_s1;
	logic       interior_s1;
	logic       last_s1;
	logic       fwd_s1;
	line_pair_t fwd_data_s1;
	logic [2*PIXEL_BITS-1:0] ram_rdata;
	line_pair_t cur_pair;
	line_pair_t wr_pair;

	// Window and median stages
	pix_t   win_q [9];
	logic   v_s2;
	logic   interior_s2;
	logic   last_s2;
	sort3_t row_sort [3];
	logic   v_s3;
	sort3_t rows_s3 [3];
	pix_t   center_s3;
	logic   interior_s3;
	logic   last_s3;
	sort3_t lo_set;
	sort3_t mid_set;
	sort3_t hi_set;
	logic   v_s4;
	pix_t   lo_s4;
	pix_t   mid_s4;
	pix_t   hi_s4;
	pix_t   center_s4;
	logic   interior_s4;
	logic   last_s4;
	sort3_t final_set;
	out_item_t result;
	logic   push;

	// Output queue
	out_item_t  slot_q [2];
	logic [1:0] count_q;
	logic       pop;

	// Clamp the configured size: zero becomes one, width saturates at the store depth.
	always_comb begin
		if (width_q == '0) begin
			w_eff = (COL_BITS+1)'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = (COL_BITS+1)'(MAX_WIDTH);
		end else begin
			w_eff = (COL_BITS+1)'(width_q);
		end
		w_last = COL_BITS'(w_eff - 1'b1);
		h_eff  = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;
		h_last = h_eff - 1'b1;
	end

	// Decide what the transaction at the input does and which output it makes.
	always_comb begin
		frame_in_done = in_row_q >= {1'b0, h_eff};
		emit0 = (in_row_q >= ROW_BITS'(2)) || (in_row_q == ROW_BITS'(1) && in_col_q != '0);
		is_drain = req_t'(pixels.req_type) == REQ_DRAIN;
		// A one-row frame needs an extra virtual pixel before its first drain.
		pre_step = pixels.valid && is_drain && frame_in_done && !emit0;
		pixels.ready = adv && !pre_step;
		accept = pixels.valid && pixels.ready;
		take = accept && (is_drain ? frame_in_done : !frame_in_done);
		issue = take || (adv && pre_step);
		pix0 = (take && !is_drain) ? pixels.pixel_in : '0;
		interior0 = out_row_q != '0 && out_row_q != h_last &&
			out_col_q != '0 && out_col_q != w_last;
		last0 = out_row_q >= h_last && out_col_q >= w_last;
	end

	// Configuration registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					width_q <= cfg_data[WIDTH_BITS-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_BITS-1:0];
				end
				default: begin
				end
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (issue) begin
			if (emit0 && last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (emit0) begin
					if (out_col_q == w_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
			end
		end
	end

	// Line store: the two rows above the incoming one, one entry per column.
	mf3_ram #(
		.WIDTH (2*PIXEL_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (adv && v_s1),
		.waddr (addr_s1),
		.wdata (wr_pair),
		.re    (adv),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	// Take the pair just written when the previous pixel used the same column.
	always_comb begin
		cur_pair = fwd_s1 ? fwd_data_s1 : line_pair_t'(ram_rdata);
		wr_pair.upper  = cur_pair.middle;
		wr_pair.middle = pix_s1;
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Row sorts of the current window
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			row_sort[k] = sort3(win_q[3*k], win_q[3*k+1], win_q[3*k+2]);
		end
	end

	// Column step of the median network
	always_comb begin
		lo_set  = sort3(rows_s3[0].lo, rows_s3[1].lo, rows_s3[2].lo);
		mid_set = sort3(rows_s3[0].mid, rows_s3[1].mid, rows_s3[2].mid);
		hi_set  = sort3(rows_s3[0].hi, rows_s3[1].hi, rows_s3[2].hi);
	end

	// Final median and border selection
	always_comb begin
		final_set    = sort3(lo_s4, mid_s4, hi_s4);
		result.pixel = interior_s4 ? final_set.mid : center_s4;
		result.last  = last_s4;
		push         = adv && v_s4;
	end

	// Pipeline payload, window shift and forwarding registers
	always_ff @(posedge clk) begin
		if (adv) begin
			addr_s1     <= in_col_q;
			pix_s1      <= pix0;
			emit_s1     <= emit0;
			interior_s1 <= interior0;
			last_s1     <= last0;
			fwd_s1      <= v_s1 && issue && addr_s1 == in_col_q;
			fwd_data_s1 <= wr_pair;

			if (v_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[3*k]   <= win_q[3*k+1];
					win_q[3*k+1] <= win_q[3*k+2];
				end
				win_q[2] <= cur_pair.upper;
				win_q[5] <= cur_pair.middle;
				win_q[8] <= pix_s1;
			end

			interior_s2 <= interior_s1;
			last_s2     <= last_s1;

			rows_s3     <= row_sort;
			center_s3   <= win_q[4];
			interior_s3 <= interior_s2;
			last_s3     <= last_s2;

			lo_s4       <= lo_set.hi;
			mid_s4      <= mid_set.mid;
			hi_s4       <= hi_set.lo;
			center_s4   <= center_s3;
			interior_s4 <= interior_s3;
			last_s4     <= last_s3;
		end
	end

	// Two-entry output queue; the pipeline holds only while it is full.
	assign adv = count_q != 2'd2;
	assign pop = filtered.valid && filtered.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push && !pop) begin
			count_q <= count_q + 1'b1;
		end else if (pop && !push) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_q[0] <= (push && count_q == 2'd1) ? result : slot_q[1];
			if (push && count_q == 2'd2) begin
				slot_q[1] <= result;
			end
		end else if (push) begin
			if (count_q == '0) begin
				slot_q[0] <= result;
			end else begin
				slot_q[1] <= result;
			end
		end
	end

	assign filtered.valid         = count_q != '0;
	assign filtered.pixel_out     = slot_q[0].pixel;
	assign filtered.last_of_frame = slot_q[0].last;

endmodule

FILE: rtl/core/mf3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the entry being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/mf3_checker.sv
// Port-level checker of the 3x3 median filter and its bind to the top level.
// Depends on mf3_pkg and on median_filter_3x3.
`timescale 1ns / 1ps

module mf3_checker import mf3_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_req_type,
	input logic out_valid,
	input logic out_ready,
	input pix_t pixel_out,
	input logic last_of_frame
);

	// A stalled output transaction stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before the transaction completed");

	// A stalled output transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_out) && $stable(last_of_frame))
		else $error("output payload changed while stalled");

	// Input is refused only when results back up or a drain needs an extra step.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid || (in_valid && in_req_type == REQ_DRAIN))
		else $error("input refused without a pending result or drain");

	// The extra step before a drain lasts a single cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready && !out_valid |=> in_ready || out_valid)
		else $error("drain held off for more than one step");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (pixels.valid),
	.in_ready      (pixels.ready),
	.in_req_type   (pixels.req_type),
	.out_valid     (filtered.valid),
	.out_ready     (filtered.ready),
	.pixel_out     (filtered.pixel_out),
	.last_of_frame (filtered.last_of_frame)
);

FILE: test/testbench.sv
// Self-checking testbench for the 3x3 median filter: directed frames, config extremes and
// random frames with noise, checked against an in-bench prediction of every output pixel.
// Depends on mf3_pkg, mf3_in_if, mf3_out_if and the median_filter_3x3 top level.
`timescale 1ns / 1ps

module testbench import mf3_pkg::*; ();

	localparam int LATENCY_PAUSE    = 16;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int RANDOM_ITEMS     = 390;

	// One expected output pixel
	typedef struct packed {
		pix_t value;
		logic last;
	} filtered_pixel_t;

	// Receiver stall patterns
	typedef enum int {
		RX_STEADY,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	// Predicts the filtered stream from accepted transactions and checks each output.
	class median_frame_checker;
		int unsigned width_reg;
		int unsigned height_reg;
		pix_t upper_line[MAX_WIDTH];
		pix_t middle_line[MAX_WIDTH];
		pix_t neighborhood[9];
		int unsigned in_col, in_row, out_col, out_row;
		filtered_pixel_t expected_pixels[$];
		int unsigned mismatches;
		int unsigned compared;
		int unsigned frames_done;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (neighborhood[i]) neighborhood[i] = '0;
			restart();
			mismatches = 0;
			compared = 0;
			frames_done = 0;
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		// Out-of-range sizes are clamped: zero becomes one, width saturates at the store depth.
		function int unsigned active_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned active_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void write_register(cfg_index_t idx, logic [CFG_BITS-1:0] data);
			case (idx)
				CFG_FRAME_WIDTH:  width_reg = data[WIDTH_BITS-1:0];
				CFG_FRAME_HEIGHT: height_reg = data[HEIGHT_BITS-1:0];
				default: ;
			endcase
			restart();
		endfunction

		function pix_t window_median();
			pix_t sorted[9];
			pix_t swap;
			sorted = neighborhood;
			for (int i = 0; i < 8; i++) begin
				for (int j = 0; j < 8 - i; j++) begin
					if (sorted[j] > sorted[j+1]) begin
						swap = sorted[j];
						sorted[j] = sorted[j+1];
						sorted[j+1] = swap;
					end
				end
			end
			return sorted[4];
		endfunction

		// Shift one pixel into the window and line stores; returns 1 if an output is due.
		function bit slide_window(pix_t value);
			int unsigned w, h, c, r;
			bit emit, interior;
			filtered_pixel_t item;
			w = active_width();
			h = active_height();
			c = in_col;
			r = in_row;
			if (c >= w) c = w - 1;
			for (int k = 0; k < 3; k++) begin
				neighborhood[k*3] = neighborhood[k*3+1];
				neighborhood[k*3+1] = neighborhood[k*3+2];
			end
			neighborhood[2] = upper_line[c];
			neighborhood[5] = middle_line[c];
			neighborhood[8] = value;
			upper_line[c] = middle_line[c];
			middle_line[c] = value;
			emit = (r >= 2) || (r == 1 && c >= 1);
			in_col = c + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row = r + 1;
			end
			if (!emit) return 0;
			interior = out_row != 0 && out_row != h - 1 && out_col != 0 && out_col != w - 1;
			item.value = interior ? window_median() : neighborhood[4];
			item.last = (out_row >= h - 1) && (out_col >= w - 1);
			expected_pixels.push_back(item);
			if (item.last) begin
				restart();
			end else begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
			return 1;
		endfunction

		// Note one accepted input transaction. Pixels after the frame is complete and
		// drains before it is complete are dropped. A drain feeds a zero pixel; on a
		// one-row frame the first drain feeds two so that it still yields a pixel.
		function void note_request(req_t kind, pix_t value);
			if (kind == REQ_PIXEL) begin
				if (in_row < active_height()) void'(slide_window(value));
			end else if (in_row >= active_height()) begin
				if (!slide_window('0)) void'(slide_window('0));
			end
		endfunction

		function void check_pixel(pix_t value, logic last);
			filtered_pixel_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output, expected none, got pixel_out %0d last_of_frame %0b",
					$time, value, last);
				return;
			end
			want = expected_pixels.pop_front();
			compared++;
			if (value !== want.value) begin
				mismatches++;
				$display("%0t: pixel_out expected %0d, got %0d", $time, want.value, value);
			end
			if (last !== want.last) begin
				mismatches++;
				$display("%0t: last_of_frame expected %0b, got %0b", $time, want.last, last);
			end
			if (want.last) frames_done++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;
	bit long_hold_request;
	int unsigned burst_left;
	int unsigned accepted_items;
	int unsigned ignored_items;

	median_frame_checker model = new();

	mf3_in_if pixels_ch ();
	mf3_out_if filtered_ch ();

	median_filter_3x3 DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixels_ch),
		.filtered  (filtered_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net in case the block hangs.
	initial begin : watchdog
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Check every output transaction.
	always @(posedge clk) begin
		if (arst_n && filtered_ch.valid && filtered_ch.ready)
			model.check_pixel(filtered_ch.pixel_out, filtered_ch.last_of_frame);
	end

	// Receiver: switches among stall patterns and honors a long hold-off on request.
	initial begin : receiver
		rx_mode_t mode;
		int unsigned mode_left;
		int unsigned phase;
		mode = RX_STEADY;
		mode_left = 0;
		phase = 0;
		filtered_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				filtered_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_STEADY:   filtered_ch.ready <= 1'b1;
					RX_RANDOM:   filtered_ch.ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: filtered_ch.ready <= (phase % 5) >= 2;
					default:     filtered_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic pix_t random_pixel();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			// A narrow range gives many equal values in a neighborhood.
			2, 3: return pix_t'($urandom_range(100, 103));
			default: return pix_t'($urandom);
		endcase
	endfunction

	// Sender pacing: bursts of random length with random gaps, sometimes none.
	task automatic pace();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 40);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap != 0) begin
			pixels_ch.valid <= 1'b0;
			repeat (gap) begin
				pixels_ch.req_type <= 1'($urandom_range(0, 1));
				pixels_ch.pixel_in <= pix_t'($urandom);
				@(posedge clk);
			end
		end
	endtask

	// Offer one input transaction and hold it until it is accepted.
	task automatic offer(req_t kind, pix_t value);
		pixels_ch.valid <= 1'b1;
		pixels_ch.req_type <= kind;
		pixels_ch.pixel_in <= value;
		@(posedge clk);
		while (!pixels_ch.ready) @(posedge clk);
		model.note_request(kind, value);
		accepted_items++;
		pace();
	endtask

	// Stop sending until every expected pixel has come out.
	task automatic wait_for_results();
		pixels_ch.valid <= 1'b0;
		do @(posedge clk); while (model.expected_pixels.size() != 0);
	endtask

	// Write both size registers; only called while the block is idle.
	task automatic set_frame(logic [CFG_BITS-1:0] w_data, logic [CFG_BITS-1:0] h_data);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w_data;
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.write_register(CFG_FRAME_WIDTH, w_data);
		model.write_register(CFG_FRAME_HEIGHT, h_data);
	endtask

	// Run one frame of random pixels with occasional dropped transactions mixed in.
	// An abandoned frame stops early and is cut short by the next register write.
	task automatic run_frame(logic [CFG_BITS-1:0] w_data, logic [CFG_BITS-1:0] h_data,
			bit abandon, bit pressure, output int unsigned sent);
		int unsigned w, h, total, cut, hold_at, pause_at, drains;
		bit do_hold, do_pause;
		sent = 0;
		wait_for_results();
		repeat (LATENCY_PAUSE) @(posedge clk);
		set_frame(w_data, h_data);
		w = model.active_width();
		h = model.active_height();
		total = w * h;
		cut = abandon ? $urandom_range(0, total - 1) : total;
		do_hold = pressure || ($urandom_range(0, 5) == 0);
		do_pause = pressure || ($urandom_range(0, 5) == 0);
		hold_at = pressure ? total / 4 : $urandom_range(0, total - 1);
		pause_at = pressure ? (3 * total) / 4 : $urandom_range(0, total - 1);
		for (int unsigned p = 0; p < cut; p++) begin
			if (do_hold && p == hold_at) long_hold_request = 1'b1;
			if (do_pause && p == pause_at) wait_for_results();
			// A drain before the frame is complete is dropped.
			if ($urandom_range(0, 29) == 0) begin
				offer(REQ_DRAIN, random_pixel());
				ignored_items++;
			end
			offer(REQ_PIXEL, random_pixel());
			sent++;
		end
		if (!abandon) begin
			drains = (h == 1) ? w : w + 1;
			for (int unsigned d = 0; d < drains; d++) begin
				// A pixel after the frame is complete is dropped until it has drained.
				if ($urandom_range(0, 14) == 0) begin
					offer(REQ_PIXEL, random_pixel());
					ignored_items++;
				end
				offer(REQ_DRAIN, random_pixel());
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		pix_t corner_values[9] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00};
		int unsigned random_items;
		int unsigned sent;
		int unsigned w_pick, h_pick;
		bit first_random;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= '0;
		pixels_ch.valid <= 1'b0;
		pixels_ch.req_type <= REQ_PIXEL;
		pixels_ch.pixel_in <= '0;
		long_hold_request = 1'b0;
		burst_left = 0;
		accepted_items = 0;
		ignored_items = 0;
		random_items = 0;
		first_random = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame with an interior pixel, plus both kinds of dropped transaction.
		set_frame(12'd3, 12'd3);
		offer(REQ_DRAIN, 8'hFF);
		ignored_items++;
		foreach (corner_values[i]) offer(REQ_PIXEL, corner_values[i]);
		offer(REQ_PIXEL, 8'h5A);
		ignored_items++;
		repeat (4) offer(REQ_DRAIN, 8'hFF);

		// Zero width and height are taken as one; a one-pixel frame needs one drain.
		wait_for_results();
		repeat (LATENCY_PAUSE) @(posedge clk);
		set_frame(12'd0, 12'd0);
		offer(REQ_PIXEL, 8'hC3);
		offer(REQ_DRAIN, 8'h3C);

		// Start a frame and leave it half done; the next register write restarts it.
		wait_for_results();
		repeat (LATENCY_PAUSE) @(posedge clk);
		set_frame(12'd4, 12'd3);
		repeat (5) offer(REQ_PIXEL, random_pixel());

		// Width above the store depth is clamped; this frame is also left unfinished.
		wait_for_results();
		repeat (LATENCY_PAUSE) @(posedge clk);
		set_frame(12'hFFF, 12'd2);
		repeat (20) offer(REQ_PIXEL, random_pixel());

		// A tall single-column frame under a long receiver hold, then a single-row frame.
		run_frame(12'd1, 12'd40, 1'b0, 1'b1, sent);
		run_frame(12'd40, 12'd1, 1'b0, 1'b0, sent);

		// Random frames, mostly small, a few wider, some abandoned part way.
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				w_pick = $urandom_range(13, 48);
				h_pick = $urandom_range(2, 6);
			end else begin
				w_pick = $urandom_range(1, 12);
				h_pick = $urandom_range(1, 8);
			end
			run_frame(CFG_BITS'(w_pick), CFG_BITS'(h_pick), $urandom_range(0, 9) == 0,
				first_random && w_pick * h_pick >= 16, sent);
			if (first_random && w_pick * h_pick >= 16) first_random = 1'b0;
			random_items += sent;
		end

		wait_for_results();
		repeat (LATENCY_PAUSE) @(posedge clk);
		$display("Ran %0d frames (sizes 1x1 up to 48 wide and 40 tall) with %0d transactions,",
			model.frames_done, accepted_items);
		$display("%0d of them dropped by design, and compared %0d output pixels.",
			ignored_items, model.compared);
		if (model.mismatches == 0 && model.expected_pixels.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/mf3_pkg.sv
rtl/core/mf3_if.sv
rtl/core/mf3_ram.sv
rtl/core/median_filter_3x3.sv
rtl/core/mf3_checker.sv
test/testbench.sv
